// ===== rtl/sbr_pkg.sv =====
// ----------------------------------------------------------------------------
// sbr_pkg: shared types and constants of the branch resolver
// Token kinds, result kinds, error codes, stack entry and result item types.
// ----------------------------------------------------------------------------
package sbr_pkg;

  localparam int unsigned MAX_TOKENS = 1024;
  localparam int unsigned COND_DEPTH = 16;
  localparam int unsigned LOOP_DEPTH = 16;

  localparam int unsigned POS_W  = $clog2(MAX_TOKENS);      // token position
  localparam int unsigned PCNT_W = $clog2(MAX_TOKENS + 1);  // position counter
  localparam int unsigned CCNT_W = $clog2(COND_DEPTH + 1);
  localparam int unsigned LCNT_W = $clog2(LOOP_DEPTH + 1);

  localparam int unsigned MAX_RES = 3;   // results per item at most
  localparam int unsigned RQ_DEPTH = 2;  // result group queue depth
  localparam int unsigned RQ_PW   = $clog2(RQ_DEPTH);
  localparam int unsigned RQ_CW   = $clog2(RQ_DEPTH + 1);

  typedef enum logic [3:0] {
    K_OTHER  = 4'd0,
    K_IF     = 4'd1,
    K_THEN   = 4'd2,
    K_ELSE   = 4'd3,
    K_END    = 4'd4,
    K_START  = 4'd5,
    K_FOR    = 4'd6,
    K_NEXT   = 4'd7,
    K_STEP   = 4'd8,
    K_ARROW  = 4'd9,
    K_DO     = 4'd10,
    K_UNTIL  = 4'd11,
    K_WHILE  = 4'd12,
    K_REPEAT = 4'd13
  } kind_e;

  typedef enum logic [1:0] {
    RK_PATCH = 2'd0,
    RK_ERROR = 2'd1,
    RK_DONE  = 2'd2
  } rkind_e;

  typedef enum logic [1:0] {
    CT_IF    = 2'd0,
    CT_DO    = 2'd1,
    CT_WHILE = 2'd2
  } ctype_e;

  localparam logic [4:0] ERR_THEN_NO_END     = 5'd0;
  localparam logic [4:0] ERR_THEN_NO_IF      = 5'd1;
  localparam logic [4:0] ERR_THEN_DUP        = 5'd2;
  localparam logic [4:0] ERR_ELSE_NO_END     = 5'd3;
  localparam logic [4:0] ERR_ELSE_NO_IF      = 5'd4;
  localparam logic [4:0] ERR_ELSE_NO_THEN    = 5'd5;
  localparam logic [4:0] ERR_ELSE_DUP        = 5'd6;
  localparam logic [4:0] ERR_NEXT_NO_START   = 5'd7;
  localparam logic [4:0] ERR_STEP_NO_START   = 5'd8;
  localparam logic [4:0] ERR_UNTIL_NO_END    = 5'd9;
  localparam logic [4:0] ERR_NO_DO           = 5'd10;
  localparam logic [4:0] ERR_UNTIL_DUP       = 5'd11;
  localparam logic [4:0] ERR_NO_WHILE        = 5'd12;
  localparam logic [4:0] ERR_REPEAT_DUP      = 5'd13;
  localparam logic [4:0] ERR_END_NO_BRANCH   = 5'd14;
  localparam logic [4:0] ERR_NO_UNTIL        = 5'd15;
  localparam logic [4:0] ERR_NO_REPEAT       = 5'd16;
  localparam logic [4:0] ERR_NO_THEN         = 5'd17;
  localparam logic [4:0] ERR_COND_OPEN       = 5'd18;
  localparam logic [4:0] ERR_LOOP_OPEN       = 5'd19;
  localparam logic [4:0] ERR_OVERFLOW        = 5'd20;
  localparam logic [4:0] ERR_TOO_LONG        = 5'd21;

  localparam logic [1:0] SLOT_1 = 2'd1;
  localparam logic [1:0] SLOT_2 = 2'd2;
  localparam logic [1:0] SLOT_3 = 2'd3;

  // first member sits in the highest bits
  typedef struct packed {
    logic [4:0]      error_code;
    logic [POS_W:0]  jump_value;
    logic [1:0]      slot;
    logic [POS_W-1:0] target_pos;
    rkind_e          result_kind;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] r;
    logic [1:0]         n;
  } grp_t;

  typedef struct packed {
    logic [POS_W-1:0] open_pos;
    logic [POS_W-1:0] mid_pos;
    logic             mid_ok;
    logic [POS_W-1:0] else_pos;
    logic             else_ok;
    ctype_e           ctype;
  } cond_ent_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic upd;
  } stk_op_t;

  function automatic res_t mk_patch(logic [POS_W-1:0] pos, logic [1:0] sl,
                                    logic [POS_W:0] val);
    res_t r;
    r.error_code  = '0;
    r.jump_value  = val;
    r.slot        = sl;
    r.target_pos  = pos;
    r.result_kind = RK_PATCH;
    return r;
  endfunction

endpackage

// ===== rtl/structured_branch_resolver.sv =====
// ----------------------------------------------------------------------------
// structured_branch_resolver: jump target resolution for structured words
// An accepted item's result group is registered into a queue and sent after
// earlier groups. One item per cycle while results drain as fast; results leave
// one per cycle while ready (up to 3 per item); input stalls while two groups wait.
// Reset clears position, stack counts, failure flag and queue; no clear pass.
// ----------------------------------------------------------------------------
module structured_branch_resolver import sbr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // [3:0] kind, [7:4] zero
  input  logic        s_tuser_i,   // [0] first_token
  input  logic        s_tlast_i,   // last_token
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [31:0] m_tdata_o,   // [1:0] result_kind, [11:2] target_pos,
                                   // [13:12] slot, [24:14] jump_value,
                                   // [29:25] error_code, [31:30] zero
  output logic        m_tlast_o    // last_of_run
);

  // Architecture: each stack is a row of cells, top of stack in cell 0.
  // A push shifts every cell down by one, a pop shifts them up, and only
  // cell 0 is ever rewritten in place (then/else/until/repeat). So every
  // token sees its top entries directly and is resolved combinationally. The
  // results of a token (at most three) go as one group into a small queue
  // that sends them out one per cycle while the output is ready.

  logic              acc, qfull;
  logic [3:0]        kind;
  logic              first, last;

  logic [PCNT_W-1:0] pos_q, pos_d, pos_e;
  logic [CCNT_W-1:0] cc_q, cc_d, cc_e;
  logic [LCNT_W-1:0] lc_q, lc_d, lc_e;
  logic              fail_q, fail_d, fail_e;

  cond_ent_t         cent [COND_DEPTH];
  logic [POS_W-1:0]  lent [LOOP_DEPTH];
  stk_op_t           cop, lop, cop_g, lop_g;
  cond_ent_t         cnew, cupd, ctop;
  logic [POS_W-1:0]  ltop;

  logic [POS_W-1:0]  cur;
  logic [POS_W:0]    nx, cur_x, open_x;
  res_t [MAX_RES-1:0] p;
  logic [1:0]        np;
  logic              err_v, done_v;
  logic [4:0]        err_c;
  res_t              tail;
  grp_t              grp;

  assign kind  = s_tdata_i[3:0];
  assign first = s_tuser_i;
  assign last  = s_tlast_i;

  assign s_tready_o = !qfull;
  assign acc        = s_tvalid_i & s_tready_o;

  // first token clears the program state before this token is taken
  assign pos_e  = first ? '0 : pos_q;
  assign cc_e   = first ? '0 : cc_q;
  assign lc_e   = first ? '0 : lc_q;
  assign fail_e = first ? 1'b0 : fail_q;

  assign ctop   = cent[0];
  assign ltop   = lent[0];
  assign cur    = pos_e[POS_W-1:0];
  assign cur_x  = {1'b0, cur};
  assign nx     = cur_x + 1'b1;
  assign open_x = {1'b0, ctop.open_pos} + 1'b1;

  // ---- token decode and stack control ----
  always_comb begin
    pos_d  = pos_e;
    cc_d   = cc_e;
    lc_d   = lc_e;
    fail_d = fail_e;
    cop    = '0;
    lop    = '0;
    cupd   = ctop;
    cnew.open_pos = cur;
    cnew.mid_pos  = '0;
    cnew.mid_ok   = 1'b0;
    cnew.else_pos = '0;
    cnew.else_ok  = 1'b0;
    cnew.ctype    = CT_IF;
    p      = '0;
    np     = 2'd0;
    err_v  = 1'b0;
    err_c  = '0;
    done_v = 1'b0;

    if (!fail_e) begin
      if (pos_e >= PCNT_W'(MAX_TOKENS)) begin
        err_v = 1'b1;
        err_c = ERR_TOO_LONG;
      end else begin
        case (kind)
          K_IF, K_DO, K_WHILE: begin
            cnew.ctype = (kind == K_DO)    ? CT_DO :
                         (kind == K_WHILE) ? CT_WHILE : CT_IF;
            if (cc_e >= CCNT_W'(COND_DEPTH)) begin
              err_v = 1'b1;
              err_c = ERR_OVERFLOW;
            end else begin
              cop.push = 1'b1;
              cc_d     = cc_e + 1'b1;
            end
          end
          K_THEN: begin
            err_v = 1'b1;
            if (last) begin
              err_c = ERR_THEN_NO_END;
            end else if (cc_e == '0) begin
              err_c = ERR_THEN_NO_IF;
            end else if (ctop.mid_ok) begin
              err_c = ERR_THEN_DUP;
            end else begin
              err_v        = 1'b0;
              cop.upd      = 1'b1;
              cupd.mid_pos = cur;
              cupd.mid_ok  = 1'b1;
              p[0] = mk_patch(cur, SLOT_1, nx);
              p[1] = mk_patch(cur, SLOT_3, {1'b0, ctop.open_pos});
              np   = 2'd2;
            end
          end
          K_ELSE: begin
            err_v = 1'b1;
            if (last) begin
              err_c = ERR_ELSE_NO_END;
            end else if (cc_e == '0) begin
              err_c = ERR_ELSE_NO_IF;
            end else if (!ctop.mid_ok) begin
              err_c = ERR_ELSE_NO_THEN;
            end else if (ctop.else_ok) begin
              err_c = ERR_ELSE_DUP;
            end else begin
              err_v         = 1'b0;
              cop.upd       = 1'b1;
              cupd.else_pos = cur;
              cupd.else_ok  = 1'b1;
              p[0] = mk_patch(cur, SLOT_1, nx);
              p[1] = mk_patch(cur, SLOT_3, {1'b0, ctop.open_pos});
              p[2] = mk_patch(ctop.mid_pos, SLOT_2, nx);
              np   = 2'd3;
            end
          end
          K_START, K_FOR: begin
            if (lc_e >= LCNT_W'(LOOP_DEPTH)) begin
              err_v = 1'b1;
              err_c = ERR_OVERFLOW;
            end else begin
              lop.push = 1'b1;
              lc_d     = lc_e + 1'b1;
              if (kind == K_FOR) begin
                p[0] = mk_patch(cur, SLOT_1, nx);
                np   = 2'd1;
              end
            end
          end
          K_NEXT, K_STEP: begin
            if (lc_e == '0) begin
              err_v = 1'b1;
              err_c = (kind == K_NEXT) ? ERR_NEXT_NO_START : ERR_STEP_NO_START;
            end else begin
              lop.pop = 1'b1;
              lc_d    = lc_e - 1'b1;
              p[0] = mk_patch(cur, SLOT_1, {1'b0, ltop});
              p[1] = mk_patch(ltop, SLOT_2, cur_x);
              np   = 2'd2;
            end
          end
          K_ARROW: begin
            p[0] = mk_patch(cur, SLOT_1, cur_x);
            np   = 2'd1;
          end
          K_UNTIL: begin
            err_v = 1'b1;
            if (last) begin
              err_c = ERR_UNTIL_NO_END;
            end else if (cc_e == '0 || ctop.ctype != CT_DO) begin
              err_c = ERR_NO_DO;
            end else if (ctop.mid_ok) begin
              err_c = ERR_UNTIL_DUP;
            end else begin
              err_v        = 1'b0;
              cop.upd      = 1'b1;
              cupd.mid_pos = cur;
              cupd.mid_ok  = 1'b1;
            end
          end
          K_REPEAT: begin
            err_v = 1'b1;
            if (cc_e == '0 || ctop.ctype != CT_WHILE) begin
              err_c = ERR_NO_WHILE;
            end else if (ctop.mid_ok) begin
              err_c = ERR_REPEAT_DUP;
            end else begin
              err_v        = 1'b0;
              cop.upd      = 1'b1;
              cupd.mid_pos = cur;
              cupd.mid_ok  = 1'b1;
            end
          end
          K_END: begin
            if (cc_e == '0) begin
              err_v = 1'b1;
              err_c = ERR_END_NO_BRANCH;
            end else begin
              case (ctop.ctype)
                CT_DO: begin
                  if (!ctop.mid_ok) begin
                    err_v = 1'b1;
                    err_c = ERR_NO_UNTIL;
                  end else begin
                    p[0] = mk_patch(cur, SLOT_1, open_x);
                    np   = 2'd1;
                  end
                end
                CT_WHILE: begin
                  // the back jump is patched even when repeat is missing
                  p[0] = mk_patch(cur, SLOT_2, open_x);
                  np   = 2'd1;
                  if (!ctop.mid_ok) begin
                    err_v = 1'b1;
                    err_c = ERR_NO_REPEAT;
                  end else begin
                    p[1] = mk_patch(ctop.mid_pos, SLOT_1, nx);
                    np   = 2'd2;
                  end
                end
                default: begin
                  if (ctop.else_ok) begin
                    p[0] = mk_patch(ctop.else_pos, SLOT_2, cur_x);
                    np   = 2'd1;
                  end else if (ctop.mid_ok) begin
                    p[0] = mk_patch(ctop.mid_pos, SLOT_2, cur_x);
                    np   = 2'd1;
                  end else begin
                    err_v = 1'b1;
                    err_c = ERR_NO_THEN;
                  end
                end
              endcase
              if (!err_v) begin
                cop.pop = 1'b1;
                cc_d    = cc_e - 1'b1;
              end
            end
          end
          default: ;
        endcase
        pos_d = pos_e + 1'b1;
      end

      // last token: anything still open is an error, else report done
      if (!err_v && last) begin
        if (cc_d != '0) begin
          err_v = 1'b1;
          err_c = ERR_COND_OPEN;
        end else if (lc_d != '0) begin
          err_v = 1'b1;
          err_c = ERR_LOOP_OPEN;
        end else begin
          done_v = 1'b1;
        end
      end
      if (err_v || last) begin
        fail_d = 1'b1;
      end
    end
  end

  // ---- result group: patches, then one error or done item ----
  always_comb begin
    tail.error_code  = err_c;
    tail.jump_value  = '0;
    tail.slot        = '0;
    tail.target_pos  = '0;
    tail.result_kind = err_v ? RK_ERROR : RK_DONE;
    for (int k = 0; k < MAX_RES; k++) begin
      if (2'(k) < np) begin
        grp.r[k] = p[k];
      end else if (2'(k) == np) begin
        grp.r[k] = tail;
      end else begin
        grp.r[k] = '0;
      end
    end
    grp.n = np + {1'b0, (err_v | done_v)};
  end

  // ---- program state ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      cc_q   <= '0;
      lc_q   <= '0;
      fail_q <= 1'b0;
    end else if (acc) begin
      pos_q  <= pos_d;
      cc_q   <= cc_d;
      lc_q   <= lc_d;
      fail_q <= fail_d;
    end
  end

  assign cop_g = acc ? cop : '0;
  assign lop_g = acc ? lop : '0;

  // ---- conditional stack cells ----
  for (genvar k = 0; k < COND_DEPTH; k++) begin : g_cc
    stk_op_t   op;
    cond_ent_t above, below;
    assign op.push = cop_g.push;
    assign op.pop  = cop_g.pop;
    assign op.upd  = cop_g.upd & (k == 0);
    if (k == 0) begin : g_top
      assign above = cnew;
    end else begin : g_mid
      assign above = cent[k-1];
    end
    if (k == COND_DEPTH - 1) begin : g_bot
      assign below = cent[k];
    end else begin : g_inn
      assign below = cent[k+1];
    end
    sbr_ccell u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .above_i (above),
      .below_i (below),
      .upd_i   (cupd),
      .ent_o   (cent[k])
    );
  end

  // ---- loop stack cells ----
  for (genvar k = 0; k < LOOP_DEPTH; k++) begin : g_lc
    logic [POS_W-1:0] above, below;
    if (k == 0) begin : g_top
      assign above = cur;
    end else begin : g_mid
      assign above = lent[k-1];
    end
    if (k == LOOP_DEPTH - 1) begin : g_bot
      assign below = lent[k];
    end else begin : g_inn
      assign below = lent[k+1];
    end
    sbr_lcell u_cell (
      .clk_i   (clk_i),
      .op_i    (lop_g),
      .above_i (above),
      .below_i (below),
      .ent_o   (lent[k])
    );
  end

  // ---- result queue and output ----
  res_t res;

  sbr_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (acc && (grp.n != 2'd0)),
    .grp_i   (grp),
    .full_o  (qfull),
    .valid_o (m_tvalid_o),
    .ready_i (m_tready_i),
    .res_o   (res),
    .last_o  (m_tlast_o)
  );

  assign m_tdata_o = {2'b00, res};

endmodule

// ===== rtl/sbr_ccell.sv =====
// ----------------------------------------------------------------------------
// sbr_ccell: one cell of the conditional construct stack
// Holds one entry; takes its upper neighbor on push, its lower on pop, the update on upd.
// ----------------------------------------------------------------------------
module sbr_ccell import sbr_pkg::*; (
  input  logic      clk_i,
  input  stk_op_t   op_i,
  input  cond_ent_t above_i,
  input  cond_ent_t below_i,
  input  cond_ent_t upd_i,
  output cond_ent_t ent_o
);

  cond_ent_t ent_q, ent_d;

  always_comb begin
    ent_d = ent_q;
    if (op_i.push) begin
      ent_d = above_i;
    end else if (op_i.pop) begin
      ent_d = below_i;
    end else if (op_i.upd) begin
      ent_d = upd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

// ===== rtl/sbr_lcell.sv =====
// ----------------------------------------------------------------------------
// sbr_lcell: one cell of the loop stack
// Holds an opening position; shifts down on push, up on pop.
// ----------------------------------------------------------------------------
module sbr_lcell import sbr_pkg::*; (
  input  logic             clk_i,
  input  stk_op_t          op_i,
  input  logic [POS_W-1:0] above_i,
  input  logic [POS_W-1:0] below_i,
  output logic [POS_W-1:0] ent_o
);

  logic [POS_W-1:0] ent_q, ent_d;

  always_comb begin
    ent_d = ent_q;
    if (op_i.push) begin
      ent_d = above_i;
    end else if (op_i.pop) begin
      ent_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

// ===== rtl/sbr_resq.sv =====
// ----------------------------------------------------------------------------
// sbr_resq: result group queue and serializer
// Queues the result groups of items and sends their results one per cycle while ready.
// ----------------------------------------------------------------------------
module sbr_resq import sbr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  grp_t grp_i,
  output logic full_o,
  output logic valid_o,
  input  logic ready_i,
  output res_t res_o,
  output logic last_o
);

  grp_t             grp_q [RQ_DEPTH];
  logic [RQ_PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [RQ_CW-1:0] cnt_q, cnt_d;
  logic [1:0]       idx_q, idx_d;
  grp_t             head;
  logic             fire, pop;

  assign head    = grp_q[rd_q];
  assign valid_o = (cnt_q != '0);
  assign last_o  = (idx_q == (head.n - 2'd1));
  assign res_o   = head.r[idx_q];
  assign full_o  = (cnt_q == RQ_CW'(RQ_DEPTH));
  assign fire    = valid_o & ready_i;
  assign pop     = fire & last_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    idx_d = idx_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == RQ_PW'(RQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (fire) begin
      idx_d = last_o ? 2'd0 : idx_q + 2'd1;
    end
    if (pop) begin
      rd_d = (rd_q == RQ_PW'(RQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      grp_q[wr_q] <= grp_i;
    end
  end

endmodule
